[design/quat_to_rotation_matrix_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to rotation matrix core
// Concurrent checks clocked on clk; one form honors reset, one does not.
// ----------------------------------------------------------------------------
`ifndef QUAT_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define QUAT_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// check outside of reset
`define QRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds through reset
`define QRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/qrm_pkg.sv]
// ----------------------------------------------------------------------------
// qrm_pkg
// Beat types, stage records and sizing for the rotation matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qrm_pkg;

  localparam int LANES      = 9;   // matrix entries
  localparam int QBITS      = 16;  // quotient bits before rounding
  localparam int DIV_STEPS  = 2;   // restoring steps per stage
  localparam int DIV_STAGES = QBITS / DIV_STEPS;
  localparam int SW         = 33;  // squared magnitude width
  localparam int RW         = 34;  // partial remainder width
  localparam int NW         = 35;  // signed numerator width

  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               degenerate;
  } rot_t;

  typedef struct packed {
    logic signed [31:0] ww;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] zz;
    logic signed [31:0] xy;
    logic signed [31:0] xz;
    logic signed [31:0] yz;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
  } prod_t;

  typedef struct packed {
    logic [LANES-1:0][RW-1:0]    r;
    logic [LANES-1:0][QBITS-1:0] q;
    logic [LANES-1:0]            neg;
    logic [SW-1:0]               s;
    logic                        degen;
  } div_t;

endpackage

`default_nettype wire

[design/qrm_mul.sv]
// ----------------------------------------------------------------------------
// qrm_mul
// First stage: the ten pairwise products of the quaternion components.
// ----------------------------------------------------------------------------
`default_nettype none

module qrm_mul
  import qrm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  vin,
  input  wire quat_t din,
  output logic       vout,
  output prod_t      dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.ww <= din.qw * din.qw;
      dout.xx <= din.qx * din.qx;
      dout.yy <= din.qy * din.qy;
      dout.zz <= din.qz * din.qz;
      dout.xy <= din.qx * din.qy;
      dout.xz <= din.qx * din.qz;
      dout.yz <= din.qy * din.qz;
      dout.wx <= din.qw * din.qx;
      dout.wy <= din.qw * din.qy;
      dout.wz <= din.qw * din.qz;
    end
  end

endmodule

`default_nettype wire

[design/qrm_numer.sv]
// ----------------------------------------------------------------------------
// qrm_numer
// Second stage: squared magnitude, nine numerators split into sign and size.
// ----------------------------------------------------------------------------
`default_nettype none

module qrm_numer
  import qrm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  vin,
  input  wire prod_t din,
  output logic       vout,
  output div_t       dout
);

  logic signed [NW-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [NW-1:0] num [LANES];
  logic signed [NW-1:0] sum;
  div_t                 nxt;

  always_comb begin
    ww = NW'(din.ww);
    xx = NW'(din.xx);
    yy = NW'(din.yy);
    zz = NW'(din.zz);
    xy = NW'(din.xy);
    xz = NW'(din.xz);
    yz = NW'(din.yz);
    wx = NW'(din.wx);
    wy = NW'(din.wy);
    wz = NW'(din.wz);
    num[0] = ww + xx - yy - zz;
    num[1] = (xy - wz) <<< 1;
    num[2] = (xz + wy) <<< 1;
    num[3] = (xy + wz) <<< 1;
    num[4] = ww - xx + yy - zz;
    num[5] = (yz - wx) <<< 1;
    num[6] = (xz - wy) <<< 1;
    num[7] = (yz + wx) <<< 1;
    num[8] = ww - xx - yy + zz;
    sum = ww + xx + yy + zz;
    nxt.s     = sum[SW-1:0];
    nxt.degen = (sum == '0);
    for (int i = 0; i < LANES; i++) begin
      nxt.neg[i] = num[i][NW-1];
      nxt.r[i]   = num[i][NW-1] ? RW'(-num[i]) : RW'(num[i]);
      nxt.q[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

`default_nettype wire

[design/qrm_div_stage.sv]
// ----------------------------------------------------------------------------
// qrm_div_stage
// One divider stage: DIV_STEPS restoring steps on all nine lanes by magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module qrm_div_stage
  import qrm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic vin,
  input  wire div_t din,
  output logic      vout,
  output div_t      dout
);

  div_t          nxt;
  logic          ge;
  logic [RW-1:0] d;

  // remainder stays below twice the divisor, so the shift never overflows
  always_comb begin
    nxt = din;
    ge  = 1'b0;
    d   = '0;
    for (int i = 0; i < LANES; i++) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        ge = (nxt.r[i] >= RW'(nxt.s));
        d  = ge ? nxt.r[i] - RW'(nxt.s) : nxt.r[i];
        nxt.r[i] = {d[RW-2:0], 1'b0};
        nxt.q[i] = {nxt.q[i][QBITS-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

`default_nettype wire

[design/quat_to_rotation_matrix_core.sv]
// ----------------------------------------------------------------------------
// quat_to_rotation_matrix_core
// Normalized quaternion to 3x3 rotation matrix, Q2.14 in and out.
// ----------------------------------------------------------------------------
//
//   channel   beat     handshake            contents
//   q         quat_t   q_valid / q_ready    qw qx qy qz
//   m         rot_t    m_valid / m_ready    m00..m22, degenerate
//
// One beat per cycle sustained while m is ready; the pipeline registers are products,
// numerators, eight divider stages of two restoring steps each (16 quotient bits),
// and the rounding output register.
// Each stage advances when it is empty or the next one advances, so bubbles
// collapse and a stall on m holds every beat in place.
// Reset (rst, synchronous) clears all stage valid bits.
//
`default_nettype none

module quat_to_rotation_matrix_core
  import qrm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire quat_t q_data,
  output logic       m_valid,
  input  wire logic  m_ready,
  output rot_t       m_data
);

  localparam int NST = DIV_STAGES + 2;

  logic              v   [NST];
  logic              en  [NST];
  logic              en_out;
  prod_t             prod;
  div_t              dv  [NST-1];
  logic signed [15:0] res [LANES];
  rot_t              m_next;
  logic [QBITS:0]    qr;
  logic [15:0]       mag;

  assign en_out = !m_valid || m_ready;

  always_comb begin
    en[NST-1] = !v[NST-1] || en_out;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign q_ready = en[0];

  qrm_mul u_mul (
    .clk (clk), .rst (rst), .en (en[0]), .vin (q_valid),
    .din (q_data), .vout (v[0]), .dout (prod)
  );

  qrm_numer u_numer (
    .clk (clk), .rst (rst), .en (en[1]), .vin (v[0]),
    .din (prod), .vout (v[1]), .dout (dv[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    qrm_div_stage u_div (
      .clk (clk), .rst (rst), .en (en[g+2]), .vin (v[g+1]),
      .din (dv[g]), .vout (v[g+2]), .dout (dv[g+1])
    );
  end

  // round half away from zero on the doubled quotient, then apply sign
  always_comb begin
    qr  = '0;
    mag = '0;
    for (int i = 0; i < LANES; i++) begin
      qr  = (QBITS+1)'(dv[NST-2].q[i]) + (QBITS+1)'(1);
      mag = qr[QBITS:1];
      if (dv[NST-2].degen) begin
        res[i] = '0;
      end else begin
        res[i] = dv[NST-2].neg[i] ? -mag : mag;
      end
    end
    m_next.m00 = res[0];
    m_next.m01 = res[1];
    m_next.m02 = res[2];
    m_next.m10 = res[3];
    m_next.m11 = res[4];
    m_next.m12 = res[5];
    m_next.m20 = res[6];
    m_next.m21 = res[7];
    m_next.m22 = res[8];
    m_next.degenerate = dv[NST-2].degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en_out) begin
      m_valid <= v[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      m_data <= m_next;
    end
  end

`include "quat_to_rotation_matrix_core_macros.svh"

  `QRM_ASSERT(a_ready_when_empty, !m_valid |-> q_ready, "input stalled with empty output")
  `QRM_ASSERT_ALWAYS(a_reset_clears, rst |=> !m_valid, "output valid right after reset")
  `QRM_ASSERT(a_degen_zero, (m_valid && m_data.degenerate) |-> (m_data.m00 == 16'sd0 && m_data.m11 == 16'sd0 && m_data.m22 == 16'sd0), "degenerate beat with nonzero diagonal")
  `QRM_ASSERT(a_entry_bound, (m_valid && !m_data.degenerate) |-> (m_data.m00 <= 16'sd16384 && m_data.m00 >= -16'sd16384), "matrix entry beyond unit magnitude")

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives quaternion beats into the rotation matrix core, predicts each matrix
// from exact integer products and a rounded scaled division, and compares
// every output beat in order. Mixes directed corners with random quaternions
// under changing sender and receiver idle rates and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

class rot_scoreboard;
  qrm_pkg::rot_t pending[$];
  int errors = 0;

  static function logic signed [15:0] round_div(longint num, longint den);
    longint mag, q;
    bit neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (2 * (mag << 14) + den) / (2 * den);
    if (q > 40000) q = 40000;
    if (neg) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function void note_quat(qrm_pkg::quat_t qin);
    qrm_pkg::rot_t r;
    longint w, x, y, z, ww, xx, yy, zz, s;
    w = qin.qw; x = qin.qx; y = qin.qy; z = qin.qz;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    s = ww + xx + yy + zz;
    r = '0;
    if (s == 0) begin
      r.degenerate = 1'b1;
    end else begin
      r.m00 = round_div(ww + xx - yy - zz, s);
      r.m01 = round_div(2 * (x * y - w * z), s);
      r.m02 = round_div(2 * (x * z + w * y), s);
      r.m10 = round_div(2 * (x * y + w * z), s);
      r.m11 = round_div(ww - xx + yy - zz, s);
      r.m12 = round_div(2 * (y * z - w * x), s);
      r.m20 = round_div(2 * (x * z - w * y), s);
      r.m21 = round_div(2 * (y * z + w * x), s);
      r.m22 = round_div(ww - xx - yy + zz, s);
    end
    pending.push_back(r);
  endfunction

  function void check_matrix(qrm_pkg::rot_t got);
    qrm_pkg::rot_t exp_m;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat got=%h", $time, got);
      errors++;
      return;
    end
    exp_m = pending.pop_front();
    if (got.m00 !== exp_m.m00) report("m00", exp_m.m00, got.m00);
    if (got.m01 !== exp_m.m01) report("m01", exp_m.m01, got.m01);
    if (got.m02 !== exp_m.m02) report("m02", exp_m.m02, got.m02);
    if (got.m10 !== exp_m.m10) report("m10", exp_m.m10, got.m10);
    if (got.m11 !== exp_m.m11) report("m11", exp_m.m11, got.m11);
    if (got.m12 !== exp_m.m12) report("m12", exp_m.m12, got.m12);
    if (got.m20 !== exp_m.m20) report("m20", exp_m.m20, got.m20);
    if (got.m21 !== exp_m.m21) report("m21", exp_m.m21, got.m21);
    if (got.m22 !== exp_m.m22) report("m22", exp_m.m22, got.m22);
    if (got.degenerate !== exp_m.degenerate)
      report("degenerate", exp_m.degenerate, got.degenerate);
  endfunction

  function void report(string fld, int e, int a);
    $display("%0t: %s mismatch expected=%0d actual=%0d", $time, fld, e, a);
    errors++;
  endfunction
endclass

module tb;
  import qrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  q_valid = 1'b0;
  logic  q_ready;
  quat_t q_data = '0;
  logic  m_valid;
  logic  m_ready = 1'b0;
  rot_t  m_data;

  int send_idle_pct = 12;
  int recv_idle_pct = 84;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  rot_scoreboard sb = new();

  quat_to_rotation_matrix_core u_top (.*);

  always #10 clk = ~clk;

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      m_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (!rst && m_valid && m_ready) sb.check_matrix(m_data);
  end

  always @(posedge clk) begin
    if ((q_valid && q_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // valid drops only while idling, so back-to-back beats keep it high
  task automatic send_quat(quat_t qin);
    while ($urandom_range(99) < send_idle_pct) begin
      q_valid <= 1'b0;
      @(posedge clk);
    end
    q_data <= qin;
    q_valid <= 1'b1;
    do @(posedge clk); while (!q_ready);
    sb.note_quat(qin);
  endtask

  task automatic send_q(int w, int x, int y, int z);
    quat_t qin;
    qin.qw = 16'(w); qin.qx = 16'(x); qin.qy = 16'(y); qin.qz = 16'(z);
    send_quat(qin);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(32767, 32700));
      2: return 16'(32'h8000 + $urandom_range(50));
      default: return 16'($urandom_range(20) - 10);
    endcase
  endfunction

  task automatic send_random(int n);
    quat_t qin;
    repeat (n) begin
      qin.qw = rand_comp(); qin.qx = rand_comp();
      qin.qy = rand_comp(); qin.qz = rand_comp();
      if ($urandom_range(49) == 0) qin = '0;
      send_quat(qin);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners: zero, identity, axes, extremes, ties, mixed signs
    send_q(0, 0, 0, 0);
    send_q(16384, 0, 0, 0);
    send_q(0, 16384, 0, 0);
    send_q(0, 0, 16384, 0);
    send_q(0, 0, 0, 16384);
    send_q(-32768, 0, 0, 0);
    send_q(32767, 32767, 32767, 32767);
    send_q(-32768, -32768, -32768, -32768);
    send_q(32767, -32768, 32767, -32768);
    send_q(1, 0, 0, 0);
    send_q(0, 0, 0, -1);
    send_q(1, 1, 1, 1);
    send_q(1, 1, 0, 0);
    send_q(3, 1, 0, 0);
    send_q(11585, 11585, 0, 0);
    send_q(-1, 2, -3, 4);
    send_q(32767, 1, 0, 0);
    send_q(1, -32768, 1, 0);
    send_q(0, 0, 0, 0);

    send_random(380);

    // long receiver hold-off while the sender keeps offering beats
    hold_cycles = 200;
    send_idle_pct = 0;
    send_random(60);

    send_idle_pct = 84;
    recv_idle_pct = 12;
    send_random(350);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(350);

    q_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule

`default_nettype wire

[quat_to_rotation_matrix_core.f]
+incdir+design
design/qrm_pkg.sv
design/qrm_mul.sv
design/qrm_numer.sv
design/qrm_div_stage.sv
design/quat_to_rotation_matrix_core.sv
dv/tb.sv
